>>> src/ffsa_pkg.sv
// ffsa_pkg: shared types and codes for the first-fit span allocator
// used by first_fit_span_allocator_top; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ffsa_pkg;

    localparam int WORD_W = 32;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_PRUNE = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_REUSED   = 2'd0,
        ST_DONE     = 2'd1,
        ST_REJECTED = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    typedef struct packed {
        logic [WORD_W-1:0] start;
        logic [WORD_W-1:0] length;
    } span_t;

    localparam int SPAN_W = 2 * WORD_W;

endpackage

`default_nettype wire

>>> src/first_fit_span_allocator_top.sv
// first_fit_span_allocator_top: first-fit span allocator with pending frees and coalescing
// depends on ffsa_pkg and ffsa_ram (free list, pending queue, merge buffer)
//
// channel  dir  tdata                                         tuser
// s_axis   in   [31:0] span_size, [63:32] span_offset         [1:0] command
// m_axis   out  [31:0] alloc_offset, [63:32] top_size,        [1:0] status
//                [95:64] peak_size
//
// one transfer at a time; an allocate scans the free list entry by entry, a
// prune runs an insertion sort on the pending ram, then a merge of free list
// and pending ram, then a copy back into the free list
// rst_n clears the counts and top/peak; the rams need no clearing
// s_tready is low while an item is worked on; a finished result waits in the
// output register, so the next item may be taken before m_tready comes
`timescale 1ns / 1ps
`default_nettype none

module first_fit_span_allocator_top
    import ffsa_pkg::*;
#(
    parameter int FREE_DEPTH    = 64,
    parameter int PENDING_DEPTH = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // span_size, span_offset
    input  wire logic [1:0]  s_tuser,   // command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [95:0] m_tdata,   // alloc_offset, top_size, peak_size
    output logic      [1:0]  m_tuser    // status
);

    localparam int MD  = FREE_DEPTH + PENDING_DEPTH;
    localparam int FAW = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;
    localparam int PAW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int MAW = $clog2(MD);
    localparam int FCW = $clog2(FREE_DEPTH + 1);
    localparam int PCW = $clog2(PENDING_DEPTH + 1);
    localparam int MCW = $clog2(MD + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_EXEC, S_F_RD, S_F_CHK, S_CARVE, S_GROW,
        S_P_START, S_KEY, S_KEYW, S_SRD, S_SCMP,
        S_M_RD, S_M_CMP, S_M_END, S_C_RD, S_C_WR, S_DONE
    } state_t;

    state_t            state_reg;
    cmd_t              cmd_reg;
    logic [31:0]       size_reg, offs_reg;
    logic [FCW-1:0]    fcnt_reg, fnz_reg, scan_reg, ci_reg;
    logic [PCW-1:0]    pcnt_reg, si_reg, sj_reg, pi_reg;
    logic [FCW-1:0]    fi_reg;
    logic [MCW-1:0]    n_reg;
    logic [31:0]       top_reg, peak_reg;
    logic              lost_reg, pruned_reg, have_reg;
    span_t             key_reg, cur_reg, fd_reg;
    logic [31:0]       res_off_reg;
    status_t           res_st_reg;
    logic              out_valid_reg;
    logic [95:0]       out_data_reg;
    logic [1:0]        out_user_reg;

    // ram ports
    logic           f_we, p_we, m_we;
    logic [FAW-1:0] f_waddr, f_raddr;
    logic [PAW-1:0] p_waddr, p_raddr;
    logic [MAW-1:0] m_waddr, m_raddr;
    span_t          f_wdata, p_wdata, m_wdata;
    logic [SPAN_W-1:0] f_rdata, p_rdata, m_rdata;
    span_t          f_rd, p_rd;

    assign f_rd = span_t'(f_rdata);
    assign p_rd = span_t'(p_rdata);

    ffsa_ram #(.WIDTH(SPAN_W), .DEPTH(FREE_DEPTH)) u_free (
        .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
        .raddr(f_raddr), .rdata(f_rdata)
    );
    ffsa_ram #(.WIDTH(SPAN_W), .DEPTH(PENDING_DEPTH)) u_pend (
        .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .raddr(p_raddr), .rdata(p_rdata)
    );
    ffsa_ram #(.WIDTH(SPAN_W), .DEPTH(MD)) u_merge (
        .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
        .raddr(m_raddr), .rdata(m_rdata)
    );

    // merge selection
    logic           f_left, p_left, take_p;
    span_t          pick;
    logic [31:0]    last_end;
    logic [PCW-1:0] sj_dec;
    logic [MCW-1:0] n_dec;
    logic           shrink;
    logic [MCW-1:0] n_fin;
    logic           n_over;
    logic [32:0]    grow_sum;
    logic [32:0]    free_end;

    always_comb
    begin
        f_left   = fi_reg < fcnt_reg;
        p_left   = pi_reg < pcnt_reg;
        take_p   = p_left && (!f_left || (p_rd.start < f_rd.start));
        pick     = take_p ? p_rd : f_rd;
        last_end = cur_reg.start + cur_reg.length;
        sj_dec   = sj_reg - PCW'(1);
        n_dec    = n_reg - MCW'(1);
        shrink   = have_reg &&
                   (({1'b0, cur_reg.start} + {1'b0, cur_reg.length}) == {1'b0, top_reg});
        n_fin    = shrink ? n_dec : n_reg;
        n_over   = n_fin > MCW'(FREE_DEPTH);
        grow_sum = {1'b0, top_reg} + {1'b0, size_reg};
        free_end = {1'b0, offs_reg} + {1'b0, size_reg};
    end

    // ram addressing
    always_comb
    begin
        f_we    = 1'b0;
        f_waddr = scan_reg[FAW-1:0];
        f_wdata = '{start: fd_reg.start + size_reg, length: fd_reg.length - size_reg};
        f_raddr = scan_reg[FAW-1:0];
        p_we    = 1'b0;
        p_waddr = sj_reg[PAW-1:0];
        p_wdata = key_reg;
        p_raddr = si_reg[PAW-1:0];
        m_we    = 1'b0;
        m_waddr = n_dec[MAW-1:0];
        m_wdata = cur_reg;
        m_raddr = MAW'(ci_reg);
        case (state_reg)
            S_EXEC:
            begin
                p_waddr = pcnt_reg[PAW-1:0];
                p_wdata = '{start: offs_reg, length: size_reg};
                p_we    = (cmd_reg == CMD_FREE) && !free_end[32] &&
                          (free_end[31:0] <= top_reg) &&
                          (pcnt_reg < PCW'(PENDING_DEPTH));
                // a free past the top is rejected even when the sum wraps
            end
            S_CARVE:
            begin
                f_we = 1'b1;
            end
            S_SRD:
            begin
                p_raddr = sj_dec[PAW-1:0];
                p_we    = (sj_reg == '0);
            end
            S_SCMP:
            begin
                p_we = 1'b1;
                if (p_rd.start > key_reg.start)
                begin
                    p_wdata = p_rd;
                end
            end
            S_M_RD:
            begin
                f_raddr = fi_reg[FAW-1:0];
                p_raddr = pi_reg[PAW-1:0];
            end
            S_M_CMP:
            begin
                // flush the previous run when a non-adjacent span starts
                m_we = (pick.length != '0) && have_reg && (last_end != pick.start);
            end
            S_M_END:
            begin
                m_we = have_reg && !shrink;
            end
            S_C_WR:
            begin
                f_we    = 1'b1;
                f_waddr = ci_reg[FAW-1:0];
                f_wdata = span_t'(m_rdata);
            end
            default:
            begin
            end
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmd_reg       <= CMD_ALLOC;
            size_reg      <= '0;
            offs_reg      <= '0;
            fcnt_reg      <= '0;
            fnz_reg       <= '0;
            scan_reg      <= '0;
            ci_reg        <= '0;
            pcnt_reg      <= '0;
            si_reg        <= '0;
            sj_reg        <= '0;
            pi_reg        <= '0;
            fi_reg        <= '0;
            n_reg         <= '0;
            top_reg       <= '0;
            peak_reg      <= '0;
            lost_reg      <= 1'b0;
            pruned_reg    <= 1'b0;
            have_reg      <= 1'b0;
            key_reg       <= '0;
            cur_reg       <= '0;
            fd_reg        <= '0;
            res_off_reg   <= '0;
            res_st_reg    <= ST_DONE;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_user_reg  <= '0;
        end
        else
        begin
            // in S_DONE the output register is reloaded below instead
            if (out_valid_reg && m_tready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        cmd_reg    <= cmd_t'(s_tuser);
                        size_reg   <= s_tdata[31:0];
                        offs_reg   <= s_tdata[63:32];
                        lost_reg   <= 1'b0;
                        pruned_reg <= 1'b0;
                        res_off_reg <= '0;
                        res_st_reg <= ST_DONE;
                        state_reg  <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    case (cmd_reg)
                        CMD_ALLOC:
                        begin
                            scan_reg  <= fnz_reg;
                            state_reg <= S_F_RD;
                        end
                        CMD_FREE:
                        begin
                            if (free_end[32] || (free_end[31:0] > top_reg))
                            begin
                                res_st_reg <= ST_REJECTED;
                            end
                            else if (pcnt_reg >= PCW'(PENDING_DEPTH))
                            begin
                                res_st_reg <= ST_OVERFLOW;
                            end
                            else
                            begin
                                pcnt_reg <= pcnt_reg + PCW'(1);
                            end
                            state_reg <= S_DONE;
                        end
                        CMD_PRUNE:
                        begin
                            state_reg <= S_P_START;
                        end
                        default:
                        begin
                            fcnt_reg  <= '0;
                            pcnt_reg  <= '0;
                            fnz_reg   <= '0;
                            top_reg   <= '0;
                            peak_reg  <= '0;
                            state_reg <= S_DONE;
                        end
                    endcase
                end
                S_F_RD:
                begin
                    if (scan_reg < fcnt_reg)
                    begin
                        state_reg <= S_F_CHK;
                    end
                    else if (!pruned_reg && (pcnt_reg != '0))
                    begin
                        pruned_reg <= 1'b1;
                        state_reg  <= S_P_START;
                    end
                    else
                    begin
                        state_reg <= S_GROW;
                    end
                end
                S_F_CHK:
                begin
                    fd_reg <= f_rd;
                    if (f_rd.length >= size_reg)
                    begin
                        state_reg <= S_CARVE;
                    end
                    else
                    begin
                        scan_reg  <= scan_reg + FCW'(1);
                        state_reg <= S_F_RD;
                    end
                end
                S_CARVE:
                begin
                    res_off_reg <= fd_reg.start;
                    res_st_reg  <= lost_reg ? ST_OVERFLOW : ST_REUSED;
                    if ((fd_reg.length == size_reg) && (fnz_reg == scan_reg))
                    begin
                        fnz_reg <= scan_reg + FCW'(1);
                    end
                    state_reg <= S_DONE;
                end
                S_GROW:
                begin
                    if (grow_sum[32])
                    begin
                        res_st_reg <= ST_OVERFLOW;
                    end
                    else
                    begin
                        res_off_reg <= top_reg;
                        top_reg     <= grow_sum[31:0];
                        if (grow_sum[31:0] > peak_reg)
                        begin
                            peak_reg <= grow_sum[31:0];
                        end
                        res_st_reg <= lost_reg ? ST_OVERFLOW : ST_DONE;
                    end
                    state_reg <= S_DONE;
                end
                S_P_START:
                begin
                    if ((pcnt_reg == '0) && (fnz_reg == '0))
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        si_reg    <= PCW'(1);
                        state_reg <= S_KEY;
                    end
                end
                // insertion sort of the pending queue by offset
                S_KEY:
                begin
                    if (si_reg >= pcnt_reg)
                    begin
                        fi_reg    <= '0;
                        pi_reg    <= '0;
                        n_reg     <= '0;
                        have_reg  <= 1'b0;
                        state_reg <= S_M_RD;
                    end
                    else
                    begin
                        state_reg <= S_KEYW;
                    end
                end
                S_KEYW:
                begin
                    key_reg   <= p_rd;
                    sj_reg    <= si_reg;
                    state_reg <= S_SRD;
                end
                S_SRD:
                begin
                    if (sj_reg == '0)
                    begin
                        si_reg    <= si_reg + PCW'(1);
                        state_reg <= S_KEY;
                    end
                    else
                    begin
                        state_reg <= S_SCMP;
                    end
                end
                S_SCMP:
                begin
                    if (p_rd.start > key_reg.start)
                    begin
                        sj_reg    <= sj_dec;
                        state_reg <= S_SRD;
                    end
                    else
                    begin
                        si_reg    <= si_reg + PCW'(1);
                        state_reg <= S_KEY;
                    end
                end
                // merge free list and sorted queue, fusing adjacent spans
                S_M_RD:
                begin
                    state_reg <= (f_left || p_left) ? S_M_CMP : S_M_END;
                end
                S_M_CMP:
                begin
                    if (take_p)
                    begin
                        pi_reg <= pi_reg + PCW'(1);
                    end
                    else
                    begin
                        fi_reg <= fi_reg + FCW'(1);
                    end
                    if (pick.length != '0)
                    begin
                        if (have_reg && (last_end == pick.start))
                        begin
                            cur_reg.length <= cur_reg.length + pick.length;
                        end
                        else
                        begin
                            cur_reg <= pick;
                            n_reg   <= n_reg + MCW'(1);
                        end
                        have_reg <= 1'b1;
                    end
                    state_reg <= S_M_RD;
                end
                S_M_END:
                begin
                    if (shrink)
                    begin
                        top_reg <= top_reg - cur_reg.length;
                    end
                    if (n_over)
                    begin
                        lost_reg <= 1'b1;
                        fcnt_reg <= FCW'(FREE_DEPTH);
                    end
                    else
                    begin
                        fcnt_reg <= n_fin[FCW-1:0];
                    end
                    pcnt_reg  <= '0;
                    fnz_reg   <= '0;
                    ci_reg    <= '0;
                    state_reg <= S_C_RD;
                end
                S_C_RD:
                begin
                    if (ci_reg >= fcnt_reg)
                    begin
                        if (cmd_reg == CMD_ALLOC)
                        begin
                            scan_reg  <= '0;
                            state_reg <= S_F_RD;
                        end
                        else
                        begin
                            res_st_reg <= lost_reg ? ST_OVERFLOW : ST_DONE;
                            state_reg  <= S_DONE;
                        end
                    end
                    else
                    begin
                        state_reg <= S_C_WR;
                    end
                end
                S_C_WR:
                begin
                    ci_reg    <= ci_reg + FCW'(1);
                    state_reg <= S_C_RD;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {peak_reg, top_reg, res_off_reg};
                        out_user_reg  <= res_st_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> src/ffsa_ram.sv
// ffsa_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module ffsa_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
